### hdl/blr_pkg.sv
// shared types and constants for the bresenham line rasterizer
// no dependencies; used by blr_clip and bresenham_line_rasterizer_top
package blr_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_DIM    = 4096;

  localparam int DIM_W     = 13;               // config register width
  localparam int DIM_IDX_W = $clog2(MAX_DIM);  // index bits of a visible coordinate
  localparam int DELTA_W   = COORD_BITS + 1;
  localparam int ERR_W     = COORD_BITS + 3;
  localparam int OFF_W     = 24;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd768;
  localparam logic [DIM_W-1:0] DIM_MAX    = DIM_W'(MAX_DIM);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [7:0]                   alpha;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;
  } in_word_t;

  typedef struct packed {
    logic                         valid_res;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         visible;
    logic [OFF_W-1:0]             pixel_offset;
    logic [COLOR_W-1:0]           pixel_color;
    logic                         last;
  } out_word_t;

  typedef struct packed {
    logic             visible;
    logic [OFF_W-1:0] offset;
  } clip_res_t;

endpackage

### hdl/bresenham_line_rasterizer_top.sv
// bresenham line rasterizer top level: walker state, config registers, result register
// depends on blr_pkg and blr_clip
//
// usage
//   input channel (in_valid_i / in_stall_o / in_word_i): a word with mode load
//   stores both endpoints and the argb colour and arms the walker, giving no
//   result. a word with mode step gives exactly one result word: the current
//   point, its on-screen flag, offset y*width+x and the colour, then moves the
//   point one bresenham step. the end point is flagged last and the walker idles.
//   a step while idle returns an all-zero word (valid_res low).
//   output channel (out_valid_o / out_stall_i / out_word_o): registered, the
//   result shows in the cycle after its step word is accepted.
//   throughput is one word per cycle, loads and steps alike; the whole step is
//   one pass of clip, 12x13 offset multiply and error update between registers.
//   while the receiver stalls a full result register, in_stall_o is raised and
//   the held result stays put; an empty or draining register never stalls input.
//   config channel (cfg_valid_i / cfg_ready_o): index 0 screen width, index 1
//   screen height, always ready; other indexes are ignored. write only when idle.
//   reset: width 1024, height 768, walker idle, result register empty.
module bresenham_line_rasterizer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  blr_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output blr_pkg::out_word_t              out_word_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [blr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [blr_pkg::DIM_W-1:0]       cfg_data_i
);
  import blr_pkg::*;

  // config registers
  logic [DIM_W-1:0] width_q, height_q;

  // walker state
  logic                         active_q, active_d;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [DELTA_W-1:0]           dx_q, dx_d, dy_q, dy_d;
  logic                         sx_neg_q, sx_neg_d, sy_neg_q, sy_neg_d;
  logic signed [ERR_W-1:0]      err_q, err_d;
  logic [COLOR_W-1:0]           color_q, color_d;

  // result register
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  logic in_acc, out_acc, is_step, at_end, move_x, move_y;
  logic signed [DELTA_W-1:0] diff_x, diff_y;
  logic [DELTA_W-1:0]        abs_x, abs_y;
  logic signed [ERR_W:0]     e2;
  clip_res_t                 clip;

  assign cfg_ready_o = 1'b1;

  // input only waits while a finished result is held by the receiver
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign is_step     = (in_word_i.mode == MODE_STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  blr_clip u_clip (
    .x_i      (cur_x_q),
    .y_i      (cur_y_q),
    .width_i  (width_q),
    .height_i (height_q),
    .clip_o   (clip)
  );

  // segment setup from the incoming endpoints
  assign diff_x = DELTA_W'(in_word_i.end_x) - DELTA_W'(in_word_i.start_x);
  assign diff_y = DELTA_W'(in_word_i.end_y) - DELTA_W'(in_word_i.start_y);
  assign abs_x  = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
  assign abs_y  = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);

  // bresenham decision on the doubled error
  assign at_end = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign e2     = {err_q[ERR_W-1], err_q} <<< 1;
  assign move_x = e2 > -$signed({2'b00, dy_q});
  assign move_y = e2 < $signed({2'b00, dx_q});

  always_comb begin
    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    sx_neg_d = sx_neg_q;
    sy_neg_d = sy_neg_q;
    err_d    = err_q;
    color_d  = color_q;

    out_valid_d = out_valid_q && !out_acc;
    out_word_d  = out_word_q;

    if (in_acc && !is_step) begin
      cur_x_d  = in_word_i.start_x;
      cur_y_d  = in_word_i.start_y;
      tgt_x_d  = in_word_i.end_x;
      tgt_y_d  = in_word_i.end_y;
      dx_d     = abs_x;
      dy_d     = abs_y;
      sx_neg_d = diff_x[DELTA_W-1] || (diff_x == '0);
      sy_neg_d = diff_y[DELTA_W-1] || (diff_y == '0);
      err_d    = ERR_W'(abs_x) - ERR_W'(abs_y);
      color_d  = {in_word_i.alpha, in_word_i.red, in_word_i.green, in_word_i.blue};
      active_d = 1'b1;
    end else if (in_acc) begin
      out_valid_d = 1'b1;
      out_word_d  = '0;
      if (active_q) begin
        out_word_d.valid_res    = 1'b1;
        out_word_d.pixel_x      = cur_x_q;
        out_word_d.pixel_y      = cur_y_q;
        out_word_d.visible      = clip.visible;
        out_word_d.pixel_offset = clip.offset;
        out_word_d.pixel_color  = color_q;
        out_word_d.last         = at_end;
        if (at_end) begin
          active_d = 1'b0;
        end else begin
          if (move_x && move_y) begin
            err_d = err_q - ERR_W'(dy_q) + ERR_W'(dx_q);
          end else if (move_x) begin
            err_d = err_q - ERR_W'(dy_q);
          end else if (move_y) begin
            err_d = err_q + ERR_W'(dx_q);
          end
          if (move_x) begin
            cur_x_d = sx_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
          end
          if (move_y) begin
            cur_y_d = sy_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, only meaningful behind active_q / out_valid_q
  always_ff @(posedge clk_i) begin
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    tgt_x_q    <= tgt_x_d;
    tgt_y_q    <= tgt_y_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    sx_neg_q   <= sx_neg_d;
    sy_neg_q   <= sy_neg_d;
    err_q      <= err_d;
    color_q    <= color_d;
    out_word_q <= out_word_d;
  end

  // a load never leaves a result behind
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_step |=> !out_valid_q)
    else $error("load word produced a result");

  // every step gives a result in the next cycle
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_step |=> out_valid_q)
    else $error("step word lost its result");

  // the end point retires the walker
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_step && active_q && at_end |=> !active_q)
    else $error("walker still active after end point");

  // last and on-screen flags only on a produced pixel
  a_flags_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_word_q.last || out_word_q.visible) |-> out_word_q.valid_res)
    else $error("flag set on an idle result");

endmodule

### hdl/blr_clip.sv
// screen clip test and linear frame-buffer offset for one point
// depends on blr_pkg
module blr_clip (
  input  logic signed [blr_pkg::COORD_BITS-1:0] x_i,
  input  logic signed [blr_pkg::COORD_BITS-1:0] y_i,
  input  logic [blr_pkg::DIM_W-1:0]             width_i,
  input  logic [blr_pkg::DIM_W-1:0]             height_i,
  output blr_pkg::clip_res_t                    clip_o
);
  import blr_pkg::*;

  localparam int PROD_W = DIM_IDX_W + DIM_W;

  logic [DIM_W-1:0]  w_sat;
  logic [DIM_W-1:0]  h_sat;
  logic              x_in;
  logic              y_in;
  logic [PROD_W-1:0] prod;

  // saturate oversized registers
  assign w_sat = (width_i  > DIM_MAX) ? DIM_MAX : width_i;
  assign h_sat = (height_i > DIM_MAX) ? DIM_MAX : height_i;

  assign x_in = !x_i[COORD_BITS-1] &&
                ({1'b0, x_i[COORD_BITS-2:0]} < COORD_BITS'(w_sat));
  assign y_in = !y_i[COORD_BITS-1] &&
                ({1'b0, y_i[COORD_BITS-2:0]} < COORD_BITS'(h_sat));

  // y * stride; only the low index bits matter once the point is on screen
  assign prod = PROD_W'(y_i[DIM_IDX_W-1:0]) * PROD_W'(w_sat);

  always_comb begin
    clip_o.visible = x_in && y_in;
    clip_o.offset  = '0;
    if (x_in && y_in) begin
      clip_o.offset = prod[OFF_W-1:0] + OFF_W'(x_i[DIM_IDX_W-1:0]);
    end
  end

endmodule

### verif/blr_pixel_checker.sv
// pixel checker for the bresenham line rasterizer: watches config, input and result channels
// depends on blr_pkg; predicts every result word and compares it field by field
module blr_pixel_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  blr_pkg::in_word_t             in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  blr_pkg::out_word_t            out_word_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [blr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [blr_pkg::DIM_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            words_checked_o,
  output int                            visible_seen_o,
  output int                            ends_seen_o,
  output int                            idle_seen_o
);

  localparam int REPORT_CAP = 40;

  // walker copy
  logic [blr_pkg::DIM_W-1:0] scr_w, scr_h;
  bit          walking;
  int          cur_x, cur_y, end_x, end_y;
  int          span_x, span_y, err_acc;
  bit          back_x, back_y;
  logic [31:0] seg_color;

  blr_pkg::out_word_t pending_pixels[$];

  function automatic int sat_dim(logic [blr_pkg::DIM_W-1:0] v);
    return (v > blr_pkg::DIM_MAX) ? blr_pkg::MAX_DIM : int'(v);
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    fail_count_o++;
    if (fail_count_o <= REPORT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h", $time, field, got, want);
  endtask

  // one accepted input word: a load rearms the walker, a step queues one pixel
  task automatic walk_word(blr_pkg::in_word_t w);
    blr_pkg::out_word_t px;
    int x1, y1, x2, y2, wd, ht, e2;
    bit on_screen, at_end;
    if (w.mode == blr_pkg::MODE_LOAD) begin
      x1 = $signed(w.start_x);
      y1 = $signed(w.start_y);
      x2 = $signed(w.end_x);
      y2 = $signed(w.end_y);
      cur_x = x1;
      cur_y = y1;
      end_x = x2;
      end_y = y2;
      span_x = (x2 > x1) ? x2 - x1 : x1 - x2;
      span_y = (y2 > y1) ? y2 - y1 : y1 - y2;
      back_x = !(x1 < x2);
      back_y = !(y1 < y2);
      err_acc = span_x - span_y;
      seg_color = {w.alpha, w.red, w.green, w.blue};
      walking = 1'b1;
    end else begin
      px = '0;
      if (walking) begin
        wd = sat_dim(scr_w);
        ht = sat_dim(scr_h);
        on_screen = cur_x >= 0 && cur_x < wd && cur_y >= 0 && cur_y < ht;
        at_end = cur_x == end_x && cur_y == end_y;
        px.valid_res = 1'b1;
        px.pixel_x = 16'(cur_x);
        px.pixel_y = 16'(cur_y);
        px.visible = on_screen;
        px.pixel_offset = on_screen ? 24'(cur_y * wd + cur_x) : '0;
        px.pixel_color = seg_color;
        px.last = at_end;
        if (at_end) begin
          walking = 1'b0;
        end else begin
          e2 = 2 * err_acc;
          if (e2 > -span_y) begin
            err_acc -= span_y;
            cur_x += back_x ? -1 : 1;
          end
          if (e2 < span_x) begin
            err_acc += span_x;
            cur_y += back_y ? -1 : 1;
          end
        end
      end
      pending_pixels.push_back(px);
    end
  endtask

  task automatic check_pixel(blr_pkg::out_word_t got);
    blr_pkg::out_word_t want;
    if (pending_pixels.size() == 0) begin
      report("result word with nothing pending", 32'(got.pixel_color), '0);
      return;
    end
    want = pending_pixels.pop_front();
    words_checked_o++;
    visible_seen_o += want.visible;
    ends_seen_o    += want.last;
    idle_seen_o    += !want.valid_res;
    if (got.valid_res !== want.valid_res)
      report("valid_res", 32'(got.valid_res), 32'(want.valid_res));
    if (got.pixel_x !== want.pixel_x)
      report("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      report("pixel_y", 32'(got.pixel_y), 32'(want.pixel_y));
    if (got.visible !== want.visible)
      report("visible", 32'(got.visible), 32'(want.visible));
    if (got.pixel_offset !== want.pixel_offset)
      report("pixel_offset", 32'(got.pixel_offset), 32'(want.pixel_offset));
    if (got.pixel_color !== want.pixel_color)
      report("pixel_color", got.pixel_color, want.pixel_color);
    if (got.last !== want.last)
      report("last", 32'(got.last), 32'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w = blr_pkg::WIDTH_RST;
      scr_h = blr_pkg::HEIGHT_RST;
      walking = 1'b0;
      cur_x = 0;
      cur_y = 0;
      end_x = 0;
      end_y = 0;
      span_x = 0;
      span_y = 0;
      err_acc = 0;
      back_x = 1'b0;
      back_y = 1'b0;
      seg_color = '0;
      pending_pixels.delete();
      fail_count_o = 0;
      words_checked_o = 0;
      visible_seen_o = 0;
      ends_seen_o = 0;
      idle_seen_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == blr_pkg::CFG_SCREEN_WIDTH) scr_w = cfg_data_i;
        else if (cfg_index_i == blr_pkg::CFG_SCREEN_HEIGHT) scr_h = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) walk_word(in_word_i);
      if (out_valid_i && !out_stall_i) check_pixel(out_word_i);
      pending_o <= pending_pixels.size();
    end
  end

endmodule

### verif/bresenham_line_rasterizer_top_test.sv
// testbench top for the bresenham line rasterizer: clock, reset, stimulus and verdict
// depends on blr_pkg, bresenham_line_rasterizer_top and blr_pixel_checker
module bresenham_line_rasterizer_top_test;
  import blr_pkg::*;

  localparam int ITEM_TARGET    = 1350;
  localparam int PHASES         = 7;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;   // result register is one stage deep

  // indexes the block has no register for, written to show they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_word_t             in_word_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_word_t            out_word_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;

  int fail_count, pending, words_checked, visible_seen, ends_seen, idle_seen;

  // screen settings per phase: reset values, the minimum, the maximum, values
  // above the maximum (saturated), zero (nothing visible) and two odd sizes
  int phase_w [PHASES] = '{1024, 1, 4096, 8191, 0, 640, 37};
  int phase_h [PHASES] = '{768, 1, 4096, 6000, 0, 480, 4095};

  bit idle_on = 1'b1;      // random gaps and stalls allowed right now
  int sent = 0;
  int loads_sent = 0;
  int steps_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  bresenham_line_rasterizer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  blr_pixel_checker pixel_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_word_i       (in_word_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_i      (out_word_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked),
    .visible_seen_o  (visible_seen),
    .ends_seen_o     (ends_seen),
    .idle_seen_o     (idle_seen)
  );

  // free-running clock, period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: stall bursts of random length, with out_stall_i dropped between bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= stall_left > 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t load_word(int x1, int y1, int x2, int y2, logic [31:0] argb);
    in_word_t w;
    w.mode    = MODE_LOAD;
    w.start_x = 16'(x1);
    w.start_y = 16'(y1);
    w.end_x   = 16'(x2);
    w.end_y   = 16'(y2);
    {w.alpha, w.red, w.green, w.blue} = argb;
    return w;
  endfunction

  // step words carry random payload: the block must ignore it
  function automatic in_word_t step_word();
    in_word_t w;
    w = load_word($urandom, $urandom, $urandom, $urandom, $urandom);
    w.mode = MODE_STEP;
    return w;
  endfunction

  // present one word, with an optional sender gap first, and hold it until taken
  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (w.mode == MODE_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  // sender goes quiet until every pending result word has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high so back-to-back writes need no toggle; caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // coordinate close to an edge of the visible range, or inside it
  function automatic int near_coord(int dim);
    int lim;
    lim = (dim > MAX_DIM) ? MAX_DIM : dim;
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(0, 8)) - 4;
      1: return lim + int'($urandom_range(0, 8)) - 4;
      default: return int'($urandom_range(0, (lim > 1) ? lim - 1 : 0));
    endcase
  endfunction

  function automatic int rand_delta();
    int d;
    if ($urandom_range(0, 5) == 0) return 0;          // axis-aligned
    d = ($urandom_range(0, 24) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  // one random segment: mostly a full walk, sometimes cut short, overrun or noise
  task automatic run_segment(int wd, int ht);
    int x1, y1, dx, dy, len, n, shape;
    shape = $urandom_range(0, 19);
    if (shape == 19) begin
      // noise: a few fully random words of either mode
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1)) send_word(step_word());
        else send_word(load_word($urandom, $urandom, $urandom, $urandom, $urandom));
      end
      return;
    end
    if ($urandom_range(0, 3) != 0) begin
      x1 = near_coord(wd);
      y1 = near_coord(ht);
    end else begin
      // anywhere in the coordinate space, kept clear of wraparound
      x1 = int'($urandom_range(0, 64935)) - 32468;
      y1 = int'($urandom_range(0, 64935)) - 32468;
    end
    dx = rand_delta();
    dy = rand_delta();
    len = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                    : (dy < 0 ? -dy : dy)) + 1;
    send_word(load_word(x1, y1, x1 + dx, y1 + dy, $urandom));
    if (shape < 16) n = len;                                // full walk, ends on last
    else if (shape < 18) n = $urandom_range(0, len - 1);    // cut short, next load replaces it
    else n = len + $urandom_range(1, 3);                    // overrun into idle steps
    repeat (n) send_word(step_word());
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SCREEN_WIDTH;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, default 1024 x 768 screen
    // step before anything was loaded: all-zero word
    send_word(step_word());
    // zero-length segment: single pixel flagged last, then idle again
    send_word(load_word(0, 0, 0, 0, 32'hFFFF_FFFF));
    send_word(step_word());
    send_word(step_word());
    // extreme endpoints, left running and dropped by the next load
    send_word(load_word(-32768, 32767, 32767, -32768, 32'h0000_0000));
    repeat (2) send_word(step_word());
    // diagonal through the bottom-right corner, stepping off screen
    send_word(load_word(1022, 766, 1024, 768, 32'h80A5_5A01));
    repeat (3) send_word(step_word());
    // horizontal right to left, crossing x = 0
    send_word(load_word(2, 5, -2, 5, 32'h7F00_FF00));
    repeat (5) send_word(step_word());
    // vertical upward, crossing y = 0
    send_word(load_word(7, 1, 7, -1, 32'h0102_0304));
    repeat (3) send_word(step_word());

    // random part, one screen setting per phase
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        // walker must be idle and every result out before the screen changes
        drain_results();
        write_reg(CFG_SCREEN_WIDTH, DIM_W'(phase_w[p]));
        write_reg(CFG_SCREEN_HEIGHT, DIM_W'(phase_h[p]));
        if (p == 5) begin
          write_reg(CFG_SPARE_A, DIM_W'($urandom));
          write_reg(CFG_SPARE_B, DIM_W'($urandom));
        end
        cfg_valid_i <= 1'b0;
      end
      while (sent < (p + 1) * ITEM_TARGET / PHASES) begin
        // last phase runs flat out; earlier phases mix busy and calm stretches
        idle_on <= (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        run_segment(phase_w[p], phase_h[p]);
      end
    end

    drain_results();
    $display("ran %0d loads and %0d steps across %0d screen sizes, 0x0 through saturated",
             loads_sent, steps_sent, PHASES);
    $display("checked %0d result words: %0d on screen, %0d segment ends, %0d idle steps",
             words_checked, visible_seen, ends_seen, idle_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
